### design/segment_table_range_extract_macros.svh
// Assertion macros used by the segment table back end.
// Depends on nothing; each user supplies i_clk and i_rst_n in scope.
`ifndef SEGMENT_TABLE_RANGE_EXTRACT_MACROS_SVH
`define SEGMENT_TABLE_RANGE_EXTRACT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ste_pkg.sv
// Package for the segment table: sizes, word types, command kinds and status codes.
// Depends on nothing.
package ste_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int LABEL_BITS   = 16;
    localparam int LBL_W        = (LABEL_BITS < 16) ? LABEL_BITS : 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int Q_DEPTH      = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [1:0] FN_CLEAR   = 2'd0;
    localparam logic [1:0] FN_APPEND  = 2'd1;
    localparam logic [1:0] FN_LOOKUP  = 2'd2;
    localparam logic [1:0] FN_EXTRACT = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY    = 2'd2;
    localparam logic [1:0] ST_EMPTY_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] seg_start;
        logic [31:0] seg_end;
        logic [15:0] seg_label;
        logic [31:0] pos_a;
        logic [31:0] pos_b;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_start;
        logic [31:0] out_end;
        logic [15:0] out_label;
        logic        last;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [2:0] {
        K_CLEAR,
        K_APPEND,
        K_LOOKUP,
        K_EXTRACT,
        K_EMPTY_RANGE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        seg_start;
        logic [31:0]        seg_end;
        logic [LBL_W-1:0]   seg_label;
        logic [31:0]        pos_a;
        logic [31:0]        pos_b;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SRCH,
        BK_SCMP,
        BK_FIXCMP,
        BK_READ,
        BK_ERR,
        BK_EMIT
    } t_bk_state;

endpackage

### design/ste_front.sv
// Front end: accepts input words, classifies them and queues the commands.
// Depends on ste_pkg.
module ste_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ste_pkg::t_in_word i_in_data,
    output logic              o_q_valid,
    output ste_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_pop
);
    import ste_pkg::*;

    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              cls;
    logic              push;

    // Classify the word; an extract over an empty range needs no table access.
    always_comb begin
        cls.seg_start = i_in_data.seg_start;
        cls.seg_end   = i_in_data.seg_end;
        cls.seg_label = i_in_data.seg_label[LBL_W-1:0];
        cls.pos_a     = i_in_data.pos_a;
        cls.pos_b     = i_in_data.pos_b;
        unique case (i_in_data.func)
            FN_CLEAR:  cls.kind = K_CLEAR;
            FN_APPEND: cls.kind = K_APPEND;
            FN_LOOKUP: cls.kind = K_LOOKUP;
            default: begin
                cls.kind = (i_in_data.pos_a == i_in_data.pos_b) ? K_EMPTY_RANGE : K_EXTRACT;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == QCNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_q_pop);
        end
    end

endmodule

### design/ste_back.sv
// Back end: segment memories, binary search sequencer and result register.
// Depends on ste_pkg and segment_table_range_extract_macros.svh.
`include "segment_table_range_extract_macros.svh"
module ste_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ste_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ste_pkg::t_out_word o_out_data
);
    import ste_pkg::*;

    logic [31:0]      start_mem [MAX_SEGMENTS];
    logic [31:0]      end_mem   [MAX_SEGMENTS];
    logic [LBL_W-1:0] label_mem [MAX_SEGMENTS];

    logic [31:0]      r_rd_start, r_rd_end;
    logic [LBL_W-1:0] r_rd_label;

    t_bk_state        r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic             r_pass, n_pass;
    logic [CNT_W-1:0] r_si, n_si, r_ei, n_ei, r_i, n_i;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic             rd_en, wr_en, out_free, is_ext, inc, fin;
    logic [IDX_W-1:0] rd_addr, cnt_m1;
    logic [IDX_W:0]   mid_sum;
    logic [31:0]      pos;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign is_ext      = (r_cmd.kind == K_EXTRACT);
    assign cnt_m1      = IDX_W'(r_cnt - 1'b1);
    assign pos         = (is_ext && !r_pass) ? r_cmd.pos_b : r_cmd.pos_a;
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hi};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            start_mem[r_cnt[IDX_W-1:0]] <= i_q_cmd.seg_start;
            end_mem[r_cnt[IDX_W-1:0]]   <= i_q_cmd.seg_end;
            label_mem[r_cnt[IDX_W-1:0]] <= i_q_cmd.seg_label;
        end
        if (rd_en) begin
            r_rd_start <= start_mem[rd_addr];
            r_rd_end   <= end_mem[rd_addr];
            r_rd_label <= label_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pass      = r_pass;
        n_si        = r_si;
        n_ei        = r_ei;
        n_i         = r_i;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = r_lo;
        inc         = 1'b0;
        fin         = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        K_CLEAR: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_cnt       = '0;
                                n_out_valid = 1'b1;
                                n_out       = '{32'd0, 32'd0, 16'd0, 1'b1, ST_OK};
                            end
                        end
                        K_APPEND: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                if (r_cnt == CNT_W'(MAX_SEGMENTS)) begin
                                    n_out = '{32'd0, 32'd0, 16'd0, 1'b1, ST_FULL};
                                end else begin
                                    wr_en = 1'b1;
                                    n_cnt = r_cnt + 1'b1;
                                    n_out = '{32'd0, 32'd0, 16'd0, 1'b1, ST_OK};
                                end
                            end
                        end
                        K_EMPTY_RANGE: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '{32'd0, 32'd0, 16'd0, 1'b1, ST_EMPTY_RANGE};
                            end
                        end
                        K_LOOKUP, K_EXTRACT: begin
                            if (r_cnt == '0) begin
                                if (out_free) begin
                                    o_q_pop     = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_out       = '{32'd0, 32'd0, 16'd0, 1'b1, ST_NO_ENTRY};
                                end
                            end else begin
                                o_q_pop = 1'b1;
                                n_cmd   = i_q_cmd;
                                n_lo    = '0;
                                n_hi    = cnt_m1;
                                n_pass  = 1'b0;
                                n_state = BK_SRCH;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid_sum[IDX_W:1];
                    rd_addr = mid_sum[IDX_W:1];
                    rd_en   = 1'b1;
                    n_state = BK_SCMP;
                end else if (is_ext && !r_pass) begin
                    // End of range found; now search for its start.
                    n_ei   = CNT_W'(r_lo);
                    n_pass = 1'b1;
                    n_lo   = '0;
                    n_hi   = cnt_m1;
                end else begin
                    n_si    = CNT_W'(r_lo);
                    rd_addr = r_lo;
                    rd_en   = 1'b1;
                    n_state = BK_FIXCMP;
                end
            end
            BK_SCMP: begin
                if (r_rd_end < pos) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = BK_SRCH;
            end
            BK_FIXCMP: begin
                // A position on a breakpoint belongs to the next segment.
                inc     = (r_cmd.pos_a == r_rd_end) &&
                          (is_ext || (r_si < CNT_W'(cnt_m1)));
                n_si    = r_si + CNT_W'(inc);
                n_i     = r_si + CNT_W'(inc);
                n_state = BK_READ;
            end
            BK_READ: begin
                if (is_ext && (r_i > r_ei)) begin
                    n_state = BK_ERR;
                end else begin
                    rd_addr = r_i[IDX_W-1:0];
                    rd_en   = 1'b1;
                    n_state = BK_EMIT;
                end
            end
            BK_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{32'd0, 32'd0, 16'd0, 1'b1, ST_NO_ENTRY};
                    n_state     = BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.out_label = 16'(r_rd_label);
                    n_out.status    = ST_OK;
                    if (is_ext) begin
                        fin           = (r_i == r_ei);
                        n_out.out_start = (r_i == r_si) ? r_cmd.pos_a : r_rd_start;
                        n_out.out_end   = fin ? r_cmd.pos_b : r_rd_end;
                    end else begin
                        fin           = 1'b1;
                        n_out.out_start = r_rd_start;
                        n_out.out_end   = r_rd_end;
                    end
                    n_out.last = fin;
                    n_i        = r_i + 1'b1;
                    n_state    = fin ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_pass <= n_pass;
        r_si   <= n_si;
        r_ei   <= n_ei;
        r_i    <= n_i;
        r_out  <= n_out;
    end

    `STE_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
    `STE_ASSERT_NOW(a_emit_in_range, r_state == BK_EMIT && is_ext, r_i <= r_ei, "walk past range end")
    `STE_ASSERT_NEXT(a_pop_idle, o_q_pop, r_state == BK_IDLE || r_state == BK_SRCH, "pop outside dispatch")

endmodule

### design/segment_table_range_extract.sv
// Segment table with binary-search label lookup and range extraction.
// Lookup speed is bounded by the single read port of the tables.
// Extract searches for the range end, then for its start, then emits one piece per covered segment.
// Clear, append and empty-range words are answered from the idle state in the back end, with no search.
// Synchronous active-low reset empties the queue, the result register and the table count.
// Depends on ste_pkg, ste_front and ste_back.
module segment_table_range_extract (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ste_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ste_pkg::t_out_word o_out_data
);
    import ste_pkg::*;

    // The front end classifies each word and holds up to two commands, so the
    // input side keeps moving while the back end searches or waits on a stall.
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    ste_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // The back end owns the segment memories and the table count. It runs the
    // binary search, a read state and a compare state per probe, and walks the emitted segments,
    // writing each result word into a register that drives the output port.
    ste_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/tb_segment_table_range_extract.sv
// Testbench for segment_table_range_extract: segment appends, label lookups and range extracts.
// Depends on ste_pkg and the segment_table_range_extract RTL; predicts every result word itself.
`timescale 1ns / 100ps

module tb_segment_table_range_extract;
    import ste_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    segment_table_range_extract i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Predictor's own copy of the segment table.
    logic [31:0] tbl_start [MAX_SEGMENTS];
    logic [31:0] tbl_end   [MAX_SEGMENTS];
    logic [15:0] tbl_label [MAX_SEGMENTS];
    int unsigned tbl_count;

    t_in_word  pending_words[$];
    t_out_word expected_pieces[$];
    int        error_count;
    bit        stimulus_done;
    bit        quiet_tail;
    bit        hold_sender;
    int        in_gap;
    int        out_gap;

    // Appends one word to the tail of the expected or the pending list.
    function automatic void add_expected(t_out_word w);
        expected_pieces.insert(expected_pieces.size(), w);
    endfunction

    function automatic void add_pending(t_in_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // Counts the breakpoints (ends of every segment but the last) strictly below pos.
    // It runs the same fixed search even when the table is unordered.
    function automatic int unsigned breakpoints_below(logic [31:0] pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = (tbl_count > 0) ? tbl_count - 1 : 0;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (tbl_end[mid % MAX_SEGMENTS] < pos) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_out_word piece(logic [31:0] s, logic [31:0] e, logic [15:0] l,
                                        logic lst, logic [1:0] st);
        t_out_word w;
        w.out_start = s;
        w.out_end   = e;
        w.out_label = l;
        w.last      = lst;
        w.status    = st;
        return w;
    endfunction

    // Applies one accepted word to the table copy and queues the pieces it must cause.
    task automatic predict_segments(t_in_word w);
        int unsigned si;
        int unsigned ei;
        int unsigned idx;
        case (w.func)
            FN_CLEAR: begin
                tbl_count = 0;
                add_expected(piece(0, 0, 0, 1'b1, ST_OK));
            end
            FN_APPEND: begin
                if (tbl_count >= MAX_SEGMENTS) begin
                    add_expected(piece(0, 0, 0, 1'b1, ST_FULL));
                end else begin
                    tbl_start[tbl_count] = w.seg_start;
                    tbl_end[tbl_count]   = w.seg_end;
                    tbl_label[tbl_count] = w.seg_label;
                    tbl_count++;
                    add_expected(piece(0, 0, 0, 1'b1, ST_OK));
                end
            end
            FN_LOOKUP: begin
                if (tbl_count == 0) begin
                    add_expected(piece(0, 0, 0, 1'b1, ST_NO_ENTRY));
                end else begin
                    // A position right on a breakpoint belongs to the next segment.
                    idx = breakpoints_below(w.pos_a);
                    if (idx < tbl_count - 1 && w.pos_a == tbl_end[idx]) idx++;
                    add_expected(piece(tbl_start[idx], tbl_end[idx],
                                       tbl_label[idx], 1'b1, ST_OK));
                end
            end
            default: begin
                if (w.pos_a == w.pos_b) begin
                    add_expected(piece(0, 0, 0, 1'b1, ST_EMPTY_RANGE));
                end else if (tbl_count == 0) begin
                    add_expected(piece(0, 0, 0, 1'b1, ST_NO_ENTRY));
                end else begin
                    si = breakpoints_below(w.pos_a);
                    ei = breakpoints_below(w.pos_b);
                    if (w.pos_a == tbl_end[si]) si++;
                    if (si > ei) begin
                        add_expected(piece(0, 0, 0, 1'b1, ST_NO_ENTRY));
                    end else if (si == ei) begin
                        add_expected(piece(w.pos_a, w.pos_b, tbl_label[si], 1'b1, ST_OK));
                    end else begin
                        // Clipped first piece, whole inner segments, clipped last piece.
                        add_expected(piece(w.pos_a, tbl_end[si], tbl_label[si],
                                           1'b0, ST_OK));
                        for (int unsigned i = si + 1; i < ei; i++) begin
                            add_expected(piece(tbl_start[i], tbl_end[i],
                                               tbl_label[i], 1'b0, ST_OK));
                        end
                        add_expected(piece(tbl_start[ei], w.pos_b, tbl_label[ei],
                                           1'b1, ST_OK));
                    end
                end
            end
        endcase
    endtask

    function automatic t_in_word make_word(logic [1:0] f, logic [31:0] s, logic [31:0] e,
                                           logic [15:0] l, logic [31:0] a, logic [31:0] b);
        t_in_word w;
        w.func      = f;
        w.seg_start = s;
        w.seg_end   = e;
        w.seg_label = l;
        w.pos_a     = a;
        w.pos_b     = b;
        return w;
    endfunction

    // Queues a clear and then n ordered contiguous segments starting at base.
    // A random step size keeps breakpoints anywhere in the 32-bit space.
    task automatic queue_table(int n, logic [31:0] base, int unsigned max_step,
                               output logic [31:0] last_end);
        logic [31:0] s;
        logic [31:0] e;
        add_pending(make_word(FN_CLEAR, $urandom, $urandom, 16'($urandom),
                              $urandom, $urandom));
        s = base;
        for (int k = 0; k < n; k++) begin
            e = s + $urandom_range(max_step, 1);
            add_pending(make_word(FN_APPEND, s, e, 16'($urandom), $urandom, $urandom));
            s = e;
        end
        last_end = s;
    endtask

    // Clock generator.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: offers the next pending word and holds it while stalled.
    // Idle bursts are only inserted between words, never while one is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // Keep the stalled word unchanged.
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap     <= in_gap - 1;
        end else if (hold_sender || pending_words.size() == 0) begin
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_in_data  <= pending_words.pop_front();
            if (!quiet_tail && $urandom_range(3, 0) == 0) in_gap <= $urandom_range(18, 1);
        end
    end

    // Predict on acceptance, so the table copy follows the order the block sees.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) predict_segments(i_in_data);
    end

    // Monitor: random receiver stalls and the field-by-field compare.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pieces.size() == 0) begin
                    $error("unexpected result word %h", o_out_data);
                    error_count++;
                end else begin
                    exp_w = expected_pieces.pop_front();
                    if (o_out_data.out_start !== exp_w.out_start) begin
                        $error("out_start expected %h actual %h",
                               exp_w.out_start, o_out_data.out_start);
                        error_count++;
                    end
                    if (o_out_data.out_end !== exp_w.out_end) begin
                        $error("out_end expected %h actual %h",
                               exp_w.out_end, o_out_data.out_end);
                        error_count++;
                    end
                    if (o_out_data.out_label !== exp_w.out_label) begin
                        $error("out_label expected %h actual %h",
                               exp_w.out_label, o_out_data.out_label);
                        error_count++;
                    end
                    if (o_out_data.last !== exp_w.last) begin
                        $error("last expected %b actual %b", exp_w.last, o_out_data.last);
                        error_count++;
                    end
                    if (o_out_data.status !== exp_w.status) begin
                        $error("status expected %0d actual %0d",
                               exp_w.status, o_out_data.status);
                        error_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap     <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(5, 0) == 0) begin
                out_gap     <= $urandom_range(18, 1) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin
        logic [31:0] top_end;
        logic [31:0] p;
        logic [31:0] q;
        int          n;
        int          cyc;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        error_count   = 0;
        stimulus_done = 1'b0;
        quiet_tail    = 1'b0;
        hold_sender   = 1'b0;
        in_gap        = 0;
        out_gap       = 0;
        tbl_count     = 0;

        // Directed part: empty table cases first, then a small table and its edges.
        add_pending(make_word(FN_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 0));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 5, 9));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 7, 7));
        add_pending(make_word(FN_APPEND, 0, 100, 16'hFFFF, 0, 0));
        add_pending(make_word(FN_APPEND, 100, 200, 16'h0000, 0, 0));
        add_pending(make_word(FN_APPEND, 200, 32'hFFFF_FFFF, 16'hA5A5, 0, 0));
        add_pending(make_word(FN_LOOKUP, 0, 0, 0, 100, 0));      // on a breakpoint
        add_pending(make_word(FN_LOOKUP, 0, 0, 0, 0, 0));
        add_pending(make_word(FN_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 0));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 50, 250));    // three pieces
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 100, 200));   // starts on a breakpoint
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 150, 60));    // reversed range
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Fill to the limit, then one append too many.
        queue_table(MAX_SEGMENTS, 0, 32'h0700_0000, top_end);
        add_pending(make_word(FN_APPEND, 1, 2, 3, 0, 0));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 0, top_end));  // all 32 pieces
        // Unordered table: the search still runs its steps.
        add_pending(make_word(FN_CLEAR, 0, 0, 0, 0, 0));
        add_pending(make_word(FN_APPEND, 0, 900, 1, 0, 0));
        add_pending(make_word(FN_APPEND, 900, 300, 2, 0, 0));
        add_pending(make_word(FN_APPEND, 300, 1000, 3, 0, 0));
        add_pending(make_word(FN_LOOKUP, 0, 0, 0, 500, 0));
        add_pending(make_word(FN_EXTRACT, 0, 0, 0, 100, 950));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random part: mostly well-formed tables of small size with probes into them.
        while (pending_words.size() > 0) @(posedge i_clk);
        for (int t = 0; t < 13; t++) begin
            n = ($urandom_range(7, 0) == 0) ? MAX_SEGMENTS : $urandom_range(8, 1);
            queue_table(n, $urandom_range(32'h1000, 0), 32'h0FFF_FFFF / n, top_end);
            for (int k = 0; k < 8; k++) begin
                p = $urandom_range(top_end, 0);
                q = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(top_end, 0);
                case ($urandom_range(9, 0))
                    0: add_pending(make_word(FN_APPEND, $urandom, $urandom,
                                             16'($urandom), $urandom, $urandom));
                    1: add_pending(make_word(FN_EXTRACT, $urandom, $urandom,
                                             16'($urandom), p, p));
                    2, 3, 4: add_pending(make_word(FN_LOOKUP, $urandom, $urandom,
                                                   16'($urandom), p, $urandom));
                    default: add_pending(make_word(FN_EXTRACT, $urandom,
                                                   $urandom, 16'($urandom), p, q));
                endcase
            end
            if (t == 7) begin
                // Let the whole backlog drain before feeding more.
                while (pending_words.size() > 0) @(posedge i_clk);
                hold_sender = 1'b1;
                while (expected_pieces.size() > 0 || i_in_valid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            if (t == 10) quiet_tail = 1'b1;
        end

        while (pending_words.size() > 0 || i_in_valid) @(posedge i_clk);
        stimulus_done = 1'b1;
        cyc = 0;
        while (expected_pieces.size() > 0 && cyc < 20000) begin
            @(posedge i_clk);
            cyc++;
        end
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_pieces.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (expected_pieces.size() > 0)
                $error("%0d expected result words never arrived", expected_pieces.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(20ms);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ste_pkg.sv
design/ste_front.sv
design/ste_back.sv
design/segment_table_range_extract.sv
tb/tb_segment_table_range_extract.sv
